@@ design/swm_pkg.sv @@
// Shared types for the sliding window maximum block: controller states, commands and status.
package swm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAIL_RD,
    ST_TAIL_CMP,
    ST_APPEND,
    ST_HEAD_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_tail;
    logic pop_tail;
    logic append;
    logic finish;
    logic rd_head;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic tail_less;
    logic window_full;
    logic out_free;
  } status_t;

endpackage

@@ design/swm_ctrl.sv @@
// Controller state machine that sequences tail removal, append and result output per word.
module swm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  swm_pkg::status_t status,
  output swm_pkg::cmd_t   cmd
);
  import swm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.count_zero ? ST_APPEND : ST_TAIL_RD;
        end
      end
      ST_TAIL_RD: begin
        cmd.rd_tail = 1'b1;
        state_next = ST_TAIL_CMP;
      end
      ST_TAIL_CMP: begin
        if (status.tail_less) begin
          cmd.pop_tail = 1'b1;
          state_next = status.count_one ? ST_APPEND : ST_TAIL_RD;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        if (status.window_full) begin
          cmd.rd_head = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/swm_datapath.sv @@
// Datapath with the deque memory, ring pointers, window counters and output register.
module swm_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [6:0]         cfg_write_data,
  input  logic signed [31:0] sample,
  input  swm_pkg::cmd_t      cmd,
  output swm_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] window_max
);
  import swm_pkg::*;

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = CW + 1;
  localparam int PW = $clog2(2 * MAX_WINDOW);

  logic signed [31:0] val_mem [MAX_WINDOW];
  logic [PW-1:0]      pos_mem [MAX_WINDOW];

  logic [6:0]         window_len;
  logic signed [31:0] cur_sample;
  logic [IW-1:0]      head;
  logic [CW-1:0]      count;
  logic [PW-1:0]      pos;
  logic [CW-1:0]      seen;
  logic signed [31:0] rd_val;
  logic [PW-1:0]      rd_pos;

  logic [CW-1:0] k;
  logic [PW-1:0] km1;
  logic [PW-1:0] oldest;
  logic [PW-1:0] pos_inc;
  logic [SW-1:0] slot_sum;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] slot_idx;
  logic [IW-1:0] tail_idx;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] rd_addr;
  logic          hit_oldest;

  always_comb begin
    if (window_len == 7'd0) begin
      k = CW'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      k = CW'(MAX_WINDOW);
    end else begin
      k = CW'(window_len);
    end
    km1 = PW'(k - CW'(1));
    if (pos >= km1) begin
      oldest = pos - km1;
    end else begin
      oldest = pos + PW'(2 * MAX_WINDOW) - km1;
    end
    pos_inc = (pos == PW'(2 * MAX_WINDOW - 1)) ? '0 : pos + PW'(1);
    slot_sum = SW'(head) + SW'(count);
    if (slot_sum >= SW'(MAX_WINDOW)) begin
      slot_sum = slot_sum - SW'(MAX_WINDOW);
    end
    tail_sum = SW'(head) + SW'(count) - SW'(1);
    if (tail_sum >= SW'(MAX_WINDOW)) begin
      tail_sum = tail_sum - SW'(MAX_WINDOW);
    end
    slot_idx = slot_sum[IW-1:0];
    tail_idx = tail_sum[IW-1:0];
    head_inc = (head == IW'(MAX_WINDOW - 1)) ? '0 : head + IW'(1);
    rd_addr = cmd.rd_head ? head : tail_idx;
    hit_oldest = (rd_pos == oldest);
  end

  assign status.count_zero  = (count == '0);
  assign status.count_one   = (count == CW'(1));
  assign status.tail_less   = (rd_val < cur_sample);
  assign status.window_full = (seen >= k);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      val_mem[slot_idx] <= cur_sample;
      pos_mem[slot_idx] <= pos;
    end
    if (cmd.rd_tail || cmd.rd_head) begin
      rd_val <= val_mem[rd_addr];
      rd_pos <= pos_mem[rd_addr];
    end
    if (cmd.accept) begin
      cur_sample <= sample;
    end
    if (cmd.emit) begin
      window_max <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= 7'd1;
      head <= '0;
      count <= '0;
      pos <= '0;
      seen <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_enable) begin
        window_len <= cfg_write_data;
        head <= '0;
        count <= '0;
        pos <= '0;
        seen <= '0;
      end else begin
        if (cmd.pop_tail) begin
          count <= count - CW'(1);
        end
        if (cmd.append) begin
          count <= count + CW'(1);
          if (seen < k) begin
            seen <= seen + CW'(1);
          end
        end
        if (cmd.emit && hit_oldest) begin
          head <= head_inc;
          count <= count - CW'(1);
        end
        if (cmd.finish) begin
          pos <= pos_inc;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= k)
    else $error("Deque holds more entries than the window length.");
  a_seen_bound: assert property (@(posedge clk) disable iff (rst) seen <= k)
    else $error("Sample count passed the window length.");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_tail |-> count != '0)
    else $error("Tail removal from an empty deque.");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free && status.window_full)
    else $error("Result word loaded while the output register was busy.");
`endif

endmodule

@@ design/sliding_window_maximum_core.sv @@
// Top level of the sliding window maximum block.
// Streaming maximum over the last window_len signed samples using a monotonic deque held in
// one memory with a single registered read port. Each input word is accepted, compared with
// the tail entries one at a time, since each tail compare needs its own memory read, then
// appended; a word that yields a result has the head entry read and emitted. A result waiting
// on out_stall holds the next word back only after that word has been accepted. No result is
// given until window_len samples have arrived, and a write to window_len restarts the stream.
module sliding_window_maximum_core #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [6:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] window_max
);
  import swm_pkg::*;

  cmd_t    cmd;
  status_t status;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .sample           (sample),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .window_max       (window_max)
  );

endmodule
